>>> sv/rld_pkg.sv
`default_nettype none

package rld_pkg;

   // fixed-point formats
   localparam int FRAC_W     = 24;
   localparam int INNER_W    = 40;
   localparam int MAG_W      = INNER_W - 1;
   localparam int DIVIDEND_W = 64;

   typedef logic signed [INNER_W-1:0] inner_type;
   typedef logic [MAG_W-1:0]          mag_type;

   localparam inner_type INNER_LIM = 40'sd549755813887;
   localparam inner_type ONE_Q24   = 40'sd16777216;

   // pipeline depths
   localparam int MUL_LAT    = 4;
   localparam int DIV_STAGES = MAG_W;
   localparam int NORM_LAT   = DIV_STAGES + 2;
   localparam int DIST_LAT   = 5 * MUL_LAT + DIV_STAGES + 6;
   localparam int PIX_LAT    = MUL_LAT + 1;
   localparam int TOTAL_LAT  = NORM_LAT + DIST_LAT + PIX_LAT;

   // register indexes
   typedef enum logic [2:0] {
      REG_K1K2   = 3'd0,
      REG_K3K4   = 3'd1,
      REG_K5K6   = 3'd2,
      REG_P1P2   = 3'd3,
      REG_FXY    = 3'd4,
      REG_CXY    = 3'd5,
      REG_BYPASS = 3'd6
   } reg_idx_type;

   // distortion coefficients, signed q8.24
   typedef struct packed {
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] k3;
      logic signed [31:0] k4;
      logic signed [31:0] k5;
      logic signed [31:0] k6;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
   } coef_type;

   // saturating add to the inner bound
   function automatic inner_type sat_add(input inner_type a, input inner_type b);
      logic signed [INNER_W:0] s;
      logic signed [INNER_W:0] lim;
      s   = {a[INNER_W-1], a} + {b[INNER_W-1], b};
      lim = {INNER_LIM[INNER_W-1], INNER_LIM};
      if (s > lim) begin
         return INNER_LIM;
      end else if (s < -lim) begin
         return -INNER_LIM;
      end
      return s[INNER_W-1:0];
   endfunction

   // magnitude of a saturated inner value
   function automatic mag_type mag_of(input inner_type a);
      logic [INNER_W-1:0] t;
      t = a[INNER_W-1] ? -a : a;
      return t[MAG_W-1:0];
   endfunction

   // sign extend a 32-bit register half
   function automatic inner_type ext32(input logic signed [31:0] a);
      return {{(INNER_W-32){a[31]}}, a};
   endfunction

endpackage

`default_nettype wire

>>> sv/rld_mul.sv
`default_nettype none

module rld_mul import rld_pkg::*; (
   input  wire logic clock,
   input  wire logic en,
   input  inner_type a,
   input  inner_type b,
   output inner_type p
);

   mag_type      am_ff;
   mag_type      bm_ff;
   logic         neg1_ff;
   logic         neg2_ff;
   logic         neg3_ff;
   logic [39:0]  ll_ff;
   logic [38:0]  lh_ff;
   logic [38:0]  hl_ff;
   logic [37:0]  hh_ff;
   logic [77:0]  prod_ff;
   inner_type    p_ff;
   logic [77:0]  prod_in;
   logic [78:0]  rnd;
   mag_type      m;
   inner_type    mp;

   // sum of partial products
   assign prod_in = {38'd0, ll_ff} + ({39'd0, lh_ff} << 20) + ({39'd0, hl_ff} << 20)
                  + ({40'd0, hh_ff} << 40);

   // round half away from zero, then saturate
   always_comb begin
      rnd = {1'b0, prod_ff} + (79'd1 << (FRAC_W - 1));
      m   = (|rnd[78:63]) ? '1 : rnd[62:24];
      mp  = {1'b0, m};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         am_ff   <= mag_of(a);
         bm_ff   <= mag_of(b);
         neg1_ff <= a[INNER_W-1] ^ b[INNER_W-1];
         ll_ff   <= {20'd0, am_ff[19:0]} * {20'd0, bm_ff[19:0]};
         lh_ff   <= {19'd0, am_ff[19:0]} * {20'd0, bm_ff[38:20]};
         hl_ff   <= {20'd0, am_ff[38:20]} * {19'd0, bm_ff[19:0]};
         hh_ff   <= {19'd0, am_ff[38:20]} * {19'd0, bm_ff[38:20]};
         neg2_ff <= neg1_ff;
         prod_ff <= prod_in;
         neg3_ff <= neg2_ff;
         p_ff    <= neg3_ff ? -mp : mp;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

>>> sv/rld_div.sv
`default_nettype none

module rld_div import rld_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [DIVIDEND_W-1:0] num,
   input  mag_type                    den,
   output mag_type                    quot
);

   logic [DIVIDEND_W-1:0] rem_ff [DIV_STAGES];
   mag_type               den_ff [DIV_STAGES];
   mag_type               q_ff   [DIV_STAGES];
   logic                  ovf_ff [DIV_STAGES];

   logic [DIVIDEND_W-1:0] rem_in [DIV_STAGES];
   mag_type               q_in   [DIV_STAGES];
   logic                  ovf_in [DIV_STAGES];
   mag_type               den_in [DIV_STAGES];

   // one quotient bit per stage, restoring
   always_comb begin
      logic [DIVIDEND_W-1:0] cur_rem;
      mag_type               cur_den;
      mag_type               cur_q;
      logic                  cur_ovf;
      logic [MAG_W+MAG_W-1:0] sub;
      logic                  take;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            cur_rem = num;
            cur_den = den;
            cur_q   = '0;
            cur_ovf = {{(MAG_W+MAG_W-DIVIDEND_W){1'b0}}, num} >= {den, {MAG_W{1'b0}}};
         end else begin
            cur_rem = rem_ff[s-1];
            cur_den = den_ff[s-1];
            cur_q   = q_ff[s-1];
            cur_ovf = ovf_ff[s-1];
         end
         sub  = {{MAG_W{1'b0}}, cur_den} << (DIV_STAGES - 1 - s);
         take = {{(MAG_W+MAG_W-DIVIDEND_W){1'b0}}, cur_rem} >= sub;
         rem_in[s] = take ? cur_rem - sub[DIVIDEND_W-1:0] : cur_rem;
         q_in[s]   = cur_q | (take ? (mag_type'(1) << (DIV_STAGES - 1 - s)) : '0);
         ovf_in[s] = cur_ovf;
         den_in[s] = cur_den;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            ovf_ff[s] <= ovf_in[s];
            den_ff[s] <= den_in[s];
         end
      end
   end

   // saturate on quotient overflow
   assign quot = ovf_ff[DIV_STAGES-1] ? '1 : q_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> sv/rld_norm.sv
`default_nettype none

module rld_norm import rld_pkg::*; (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic signed [31:0] point_x,
   input  wire logic signed [31:0] point_y,
   input  wire logic signed [31:0] point_z,
   output inner_type        xn,
   output inner_type        yn,
   output logic             z_ok
);

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic z_ok;
   } norm_side_type;

   logic [31:0]           mx;
   logic [31:0]           my;
   logic [DIVIDEND_W-1:0] dx_ff;
   logic [DIVIDEND_W-1:0] dy_ff;
   mag_type               dz_ff;
   norm_side_type         side_ff;
   norm_side_type         side_dly_ff [DIV_STAGES];
   mag_type               qx;
   mag_type               qy;
   inner_type             xn_ff;
   inner_type             yn_ff;
   logic                  ok_ff;
   inner_type             qx_s;
   inner_type             qy_s;

   // magnitudes of the point coordinates
   assign mx = point_x[31] ? 32'(-point_x) : 32'(point_x);
   assign my = point_y[31] ? 32'(-point_y) : 32'(point_y);

   // dividend with half the divisor added for rounding
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff         <= {8'd0, mx, 24'd0} + {34'd0, point_z[30:1]};
         dy_ff         <= {8'd0, my, 24'd0} + {34'd0, point_z[30:1]};
         dz_ff         <= {8'd0, point_z[30:0]};
         side_ff.neg_x <= point_x[31];
         side_ff.neg_y <= point_y[31];
         side_ff.z_ok  <= !point_z[31] && (point_z != '0);
      end
   end

   rld_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (dx_ff),
      .den   (dz_ff),
      .quot  (qx)
   );

   rld_div u_div_y (
      .clock (clock),
      .en    (en),
      .num   (dy_ff),
      .den   (dz_ff),
      .quot  (qy)
   );

   assign qx_s = {1'b0, qx};
   assign qy_s = {1'b0, qy};

   // signs ride along with the divider
   always_ff @(posedge clock) begin
      if (en) begin
         side_dly_ff[0] <= side_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            side_dly_ff[i] <= side_dly_ff[i-1];
         end
         xn_ff <= side_dly_ff[DIV_STAGES-1].neg_x ? -qx_s : qx_s;
         yn_ff <= side_dly_ff[DIV_STAGES-1].neg_y ? -qy_s : qy_s;
         ok_ff <= side_dly_ff[DIV_STAGES-1].z_ok;
      end
   end

   assign xn   = xn_ff;
   assign yn   = yn_ff;
   assign z_ok = ok_ff;

endmodule

`default_nettype wire

>>> sv/rld_distort.sv
`default_nettype none

module rld_distort import rld_pkg::*; (
   input  wire logic clock,
   input  wire logic en,
   input  coef_type  coef,
   input  wire logic bypass,
   input  inner_type xn,
   input  inner_type yn,
   input  wire logic ok_in,
   output inner_type xd,
   output inner_type yd,
   output logic      ok_out
);

   // cycle at which each value shows on its register
   localparam int T_R2    = MUL_LAT + 1;
   localparam int T_R4    = T_R2 + MUL_LAT;
   localparam int T_R6    = T_R4 + MUL_LAT;
   localparam int T_K     = T_R6 + MUL_LAT;
   localparam int T_DIVIN = T_K + 3;
   localparam int T_Q     = T_DIVIN + DIV_STAGES;
   localparam int T_RATIO = T_Q + 1;
   localparam int T_M5    = T_RATIO + MUL_LAT;
   localparam int PT_D    = T_M5;
   localparam int A1_D    = T_RATIO - T_R2;
   localparam int A23_D   = A1_D - 1;
   localparam int R2_D    = T_R6 - T_R2;
   localparam int R4_D    = T_R6 - T_R4;
   localparam int DZ_D    = T_M5 - T_DIVIN;

   typedef struct packed {
      logic      ok;
      inner_type xn;
      inner_type yn;
   } pt_type;

   pt_type    pt_dly_ff  [PT_D];
   inner_type r2_dly_ff  [R2_D];
   inner_type r4_dly_ff  [R4_D];
   inner_type a1_dly_ff  [A1_D];
   inner_type a2_dly_ff  [A23_D];
   inner_type a3_dly_ff  [A23_D];
   logic      neg_dly_ff [DIV_STAGES];
   logic      dz_dly_ff  [DZ_D];

   inner_type m_xx, m_yy, m_xy, m_r4, m_r6;
   inner_type m_k1, m_k2, m_k3, m_k4, m_k5, m_k6;
   inner_type m_xr, m_yr, m_p1a1, m_p2a2, m_p1a3, m_p2a1;
   inner_type r2_ff, a1_ff, x2_ff, y2_ff, a2_ff, a3_ff;
   inner_type n1_ff, d1_ff, k3_ff, k6_ff, num_ff, den_ff;
   logic [DIVIDEND_W-1:0] dvd_ff;
   mag_type   dvs_ff;
   logic      neg_ff;
   logic      dz_ff;
   mag_type   nm, dm, q;
   inner_type q_s;
   inner_type ratio_ff;
   inner_type xd_ff, yd_ff;
   logic      ok_ff;
   pt_type    pt_late;

   // squares and cross term
   rld_mul u_xx (.clock(clock), .en(en), .a(xn), .b(xn), .p(m_xx));
   rld_mul u_yy (.clock(clock), .en(en), .a(yn), .b(yn), .p(m_yy));
   rld_mul u_xy (.clock(clock), .en(en), .a(xn), .b(yn), .p(m_xy));

   // radius powers
   rld_mul u_r4 (.clock(clock), .en(en), .a(r2_ff), .b(r2_ff), .p(m_r4));
   rld_mul u_r6 (.clock(clock), .en(en), .a(m_r4), .b(r2_dly_ff[T_R4-T_R2-1]), .p(m_r6));

   // polynomial terms
   rld_mul u_k1 (.clock(clock), .en(en), .a(ext32(coef.k1)), .b(r2_dly_ff[R2_D-1]),
                 .p(m_k1));
   rld_mul u_k2 (.clock(clock), .en(en), .a(ext32(coef.k2)), .b(r4_dly_ff[R4_D-1]),
                 .p(m_k2));
   rld_mul u_k3 (.clock(clock), .en(en), .a(ext32(coef.k3)), .b(m_r6), .p(m_k3));
   rld_mul u_k4 (.clock(clock), .en(en), .a(ext32(coef.k4)), .b(r2_dly_ff[R2_D-1]),
                 .p(m_k4));
   rld_mul u_k5 (.clock(clock), .en(en), .a(ext32(coef.k5)), .b(r4_dly_ff[R4_D-1]),
                 .p(m_k5));
   rld_mul u_k6 (.clock(clock), .en(en), .a(ext32(coef.k6)), .b(m_r6), .p(m_k6));

   // polynomial sums and divider setup
   assign nm = mag_of(num_ff);
   assign dm = mag_of(den_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         r2_ff  <= sat_add(m_xx, m_yy);
         a1_ff  <= sat_add(m_xy, m_xy);
         x2_ff  <= sat_add(m_xx, m_xx);
         y2_ff  <= sat_add(m_yy, m_yy);
         a2_ff  <= sat_add(r2_ff, x2_ff);
         a3_ff  <= sat_add(r2_ff, y2_ff);
         n1_ff  <= sat_add(sat_add(ONE_Q24, m_k1), m_k2);
         d1_ff  <= sat_add(sat_add(ONE_Q24, m_k4), m_k5);
         k3_ff  <= m_k3;
         k6_ff  <= m_k6;
         num_ff <= sat_add(n1_ff, k3_ff);
         den_ff <= sat_add(d1_ff, k6_ff);
         dvd_ff <= {1'b0, nm, 24'd0} + {26'd0, dm[MAG_W-1:1]};
         dvs_ff <= dm;
         neg_ff <= num_ff[INNER_W-1] ^ den_ff[INNER_W-1];
         dz_ff  <= (den_ff == '0);
      end
   end

   rld_div u_div (
      .clock (clock),
      .en    (en),
      .num   (dvd_ff),
      .den   (dvs_ff),
      .quot  (q)
   );

   assign q_s = {1'b0, q};

   // delay lines that keep operands aligned
   always_ff @(posedge clock) begin
      if (en) begin
         pt_dly_ff[0]  <= '{ok: ok_in, xn: xn, yn: yn};
         r2_dly_ff[0]  <= r2_ff;
         r4_dly_ff[0]  <= m_r4;
         a1_dly_ff[0]  <= a1_ff;
         a2_dly_ff[0]  <= a2_ff;
         a3_dly_ff[0]  <= a3_ff;
         neg_dly_ff[0] <= neg_ff;
         dz_dly_ff[0]  <= dz_ff;
         for (int i = 1; i < PT_D; i++) begin
            pt_dly_ff[i] <= pt_dly_ff[i-1];
         end
         for (int i = 1; i < R2_D; i++) begin
            r2_dly_ff[i] <= r2_dly_ff[i-1];
         end
         for (int i = 1; i < R4_D; i++) begin
            r4_dly_ff[i] <= r4_dly_ff[i-1];
         end
         for (int i = 1; i < A1_D; i++) begin
            a1_dly_ff[i] <= a1_dly_ff[i-1];
         end
         for (int i = 1; i < A23_D; i++) begin
            a2_dly_ff[i] <= a2_dly_ff[i-1];
            a3_dly_ff[i] <= a3_dly_ff[i-1];
         end
         for (int i = 1; i < DIV_STAGES; i++) begin
            neg_dly_ff[i] <= neg_dly_ff[i-1];
         end
         for (int i = 1; i < DZ_D; i++) begin
            dz_dly_ff[i] <= dz_dly_ff[i-1];
         end
         ratio_ff <= neg_dly_ff[DIV_STAGES-1] ? -q_s : q_s;
      end
   end

   // ratio and tangential terms
   rld_mul u_xr (.clock(clock), .en(en), .a(pt_dly_ff[T_RATIO-1].xn), .b(ratio_ff),
                 .p(m_xr));
   rld_mul u_yr (.clock(clock), .en(en), .a(pt_dly_ff[T_RATIO-1].yn), .b(ratio_ff),
                 .p(m_yr));
   rld_mul u_p1a1 (.clock(clock), .en(en), .a(ext32(coef.p1)), .b(a1_dly_ff[A1_D-1]),
                   .p(m_p1a1));
   rld_mul u_p2a2 (.clock(clock), .en(en), .a(ext32(coef.p2)), .b(a2_dly_ff[A23_D-1]),
                   .p(m_p2a2));
   rld_mul u_p1a3 (.clock(clock), .en(en), .a(ext32(coef.p1)), .b(a3_dly_ff[A23_D-1]),
                   .p(m_p1a3));
   rld_mul u_p2a1 (.clock(clock), .en(en), .a(ext32(coef.p2)), .b(a1_dly_ff[A1_D-1]),
                   .p(m_p2a1));

   assign pt_late = pt_dly_ff[PT_D-1];

   // final sums, bypass select and validity
   always_ff @(posedge clock) begin
      if (en) begin
         xd_ff <= bypass ? pt_late.xn : sat_add(sat_add(m_xr, m_p1a1), m_p2a2);
         yd_ff <= bypass ? pt_late.yn : sat_add(sat_add(m_yr, m_p1a3), m_p2a1);
         ok_ff <= pt_late.ok && (bypass || !dz_dly_ff[DZ_D-1]);
      end
   end

   assign xd     = xd_ff;
   assign yd     = yd_ff;
   assign ok_out = ok_ff;

endmodule

`default_nettype wire

>>> sv/rld_pixel.sv
`default_nettype none

module rld_pixel import rld_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  inner_type               xd,
   input  inner_type               yd,
   input  wire logic               ok_in,
   input  wire logic signed [31:0] fx,
   input  wire logic signed [31:0] fy,
   input  wire logic signed [31:0] cx,
   input  wire logic signed [31:0] cy,
   output logic signed [31:0]      pixel_u,
   output logic signed [31:0]      pixel_v,
   output logic                    valid_res
);

   localparam logic signed [INNER_W:0] PIX_MAX = 41'sd2147483647;
   localparam logic signed [INNER_W:0] PIX_MIN = -41'sd2147483648;

   inner_type                 m_u;
   inner_type                 m_v;
   logic                      ok_dly_ff [MUL_LAT];
   logic signed [INNER_W:0]   su;
   logic signed [INNER_W:0]   sv;
   logic signed [31:0]        u_ff;
   logic signed [31:0]        v_ff;
   logic                      valid_ff;

   rld_mul u_mu (.clock(clock), .en(en), .a(ext32(fx)), .b(xd), .p(m_u));
   rld_mul u_mv (.clock(clock), .en(en), .a(ext32(fy)), .b(yd), .p(m_v));

   // add center
   assign su = {m_u[INNER_W-1], m_u} + {{(INNER_W-31){cx[31]}}, cx};
   assign sv = {m_v[INNER_W-1], m_v} + {{(INNER_W-31){cy[31]}}, cy};

   // clamp to 32 bits, zero on invalid
   always_ff @(posedge clock) begin
      if (en) begin
         ok_dly_ff[0] <= ok_in;
         for (int i = 1; i < MUL_LAT; i++) begin
            ok_dly_ff[i] <= ok_dly_ff[i-1];
         end
         valid_ff <= ok_dly_ff[MUL_LAT-1];
         if (!ok_dly_ff[MUL_LAT-1]) begin
            u_ff <= '0;
            v_ff <= '0;
         end else begin
            u_ff <= (su > PIX_MAX) ? PIX_MAX[31:0] : (su < PIX_MIN) ? PIX_MIN[31:0] : su[31:0];
            v_ff <= (sv > PIX_MAX) ? PIX_MAX[31:0] : (sv < PIX_MIN) ? PIX_MIN[31:0] : sv[31:0];
         end
      end
   end

   assign pixel_u   = u_ff;
   assign pixel_v   = v_ff;
   assign valid_res = valid_ff;

endmodule

`default_nettype wire

>>> sv/rational_lens_distort_project.sv
`default_nettype none

// channel    direction  handshake              payload
// request    in         req_valid / req_ready  req_point_x, req_point_y, req_point_z
// response   out        rsp_valid / rsp_ready  rsp_pixel_u, rsp_pixel_v, rsp_valid_res
// csr        in         csr_we                 csr_index, csr_wdata
//
// one request per cycle while the response is not stalled; results come back in request order,
// through the 39-stage restoring dividers of the projection and of the rational ratio in series.
// reset clears the valid pipeline and loads all registers with zero, bypass with one.
// a stalled response freezes the whole pipeline; req_ready drops in the same cycle.

module rational_lens_distort_project import rld_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_pixel_u,
   output logic signed [31:0]      rsp_pixel_v,
   output logic                    rsp_valid_res,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_wdata
);

   logic [63:0] k1k2_ff;
   logic [63:0] k3k4_ff;
   logic [63:0] k5k6_ff;
   logic [63:0] p1p2_ff;
   logic [63:0] fxy_ff;
   logic [63:0] cxy_ff;
   logic        bypass_ff;
   logic        vld_ff [TOTAL_LAT];
   logic        en;
   coef_type    coef;
   inner_type   xn, yn, xd, yd;
   logic        z_ok, d_ok;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         k1k2_ff   <= '0;
         k3k4_ff   <= '0;
         k5k6_ff   <= '0;
         p1p2_ff   <= '0;
         fxy_ff    <= '0;
         cxy_ff    <= '0;
         bypass_ff <= 1'b1;
      end else if (csr_we) begin
         case (reg_idx_type'(csr_index))
            REG_K1K2: begin
               k1k2_ff <= csr_wdata;
            end
            REG_K3K4: begin
               k3k4_ff <= csr_wdata;
            end
            REG_K5K6: begin
               k5k6_ff <= csr_wdata;
            end
            REG_P1P2: begin
               p1p2_ff <= csr_wdata;
            end
            REG_FXY: begin
               fxy_ff <= csr_wdata;
            end
            REG_CXY: begin
               cxy_ff <= csr_wdata;
            end
            REG_BYPASS: begin
               bypass_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign coef.k1 = k1k2_ff[63:32];
   assign coef.k2 = k1k2_ff[31:0];
   assign coef.k3 = k3k4_ff[63:32];
   assign coef.k4 = k3k4_ff[31:0];
   assign coef.k5 = k5k6_ff[63:32];
   assign coef.k6 = k5k6_ff[31:0];
   assign coef.p1 = p1p2_ff[63:32];
   assign coef.p2 = p1p2_ff[31:0];

   // pipeline advance and valid tracking
   assign en        = !vld_ff[TOTAL_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TOTAL_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < TOTAL_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   rld_norm u_norm (
      .clock   (clock),
      .en      (en),
      .point_x (req_point_x),
      .point_y (req_point_y),
      .point_z (req_point_z),
      .xn      (xn),
      .yn      (yn),
      .z_ok    (z_ok)
   );

   rld_distort u_distort (
      .clock  (clock),
      .en     (en),
      .coef   (coef),
      .bypass (bypass_ff),
      .xn     (xn),
      .yn     (yn),
      .ok_in  (z_ok),
      .xd     (xd),
      .yd     (yd),
      .ok_out (d_ok)
   );

   rld_pixel u_pixel (
      .clock     (clock),
      .en        (en),
      .xd        (xd),
      .yd        (yd),
      .ok_in     (d_ok),
      .fx        (fxy_ff[63:32]),
      .fy        (fxy_ff[31:0]),
      .cx        (cxy_ff[63:32]),
      .cy        (cxy_ff[31:0]),
      .pixel_u   (rsp_pixel_u),
      .pixel_v   (rsp_pixel_v),
      .valid_res (rsp_valid_res)
   );

endmodule

`default_nettype wire

>>> sim/rational_lens_distort_project_test.sv
`timescale 1ns / 1ps

module rational_lens_distort_project_test;
   import rld_pkg::*;

   localparam longint LIM      = 64'sd549755813887;
   localparam longint ONE      = 64'sd16777216;
   localparam int     WATCHDOG = 4000;
   localparam logic [2:0] IDX_UNUSED = 3'd7;

   typedef struct {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic               ok;
   } pixel_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_point_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_pixel_u;
   logic signed [31:0] rsp_pixel_v;
   logic               rsp_valid_res;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   // shadow copy of the register file
   logic [63:0] shadow [7];
   pixel_type   pending_pixels [$];
   int          errors = 0;
   int          requests_sent = 0;
   int          invalid_seen = 0;
   int          idle_cycles = 0;
   bit          no_gaps = 0;

   rational_lens_distort_project u_dut (.*);

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // fixed-point helpers
   function automatic longint clamp_inner(longint a);
      if (a > LIM) return LIM;
      if (a < -LIM) return -LIM;
      return a;
   endfunction

   function automatic longint half(logic [63:0] r, bit hi);
      logic signed [31:0] h;
      h = hi ? r[63:32] : r[31:0];
      return longint'(h);
   endfunction

   function automatic longint mul_round(longint a, longint b);
      logic [127:0] p;
      longint unsigned ma, mb;
      longint q;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = (128'(ma) * 128'(mb) + 128'(1 << 23)) >> 24;
      q = (p > 128'(LIM)) ? LIM : longint'(p[63:0]);
      return ((a < 0) != (b < 0)) ? -q : q;
   endfunction

   function automatic longint div_round(longint n, longint d);
      logic [127:0] un, ud, q;
      longint r;
      un = 128'(n < 0 ? -n : n);
      ud = 128'(d < 0 ? -d : d);
      q = ((un << 24) + (ud >> 1)) / ud;
      r = (q > 128'(LIM)) ? LIM : longint'(q[63:0]);
      return ((n < 0) != (d < 0)) ? -r : r;
   endfunction

   function automatic longint clamp_out(longint a);
      if (a > 64'sd2147483647) return 64'sd2147483647;
      if (a < -64'sd2147483648) return -64'sd2147483648;
      return a;
   endfunction

   // projection and distortion of one point
   function automatic pixel_type project_point(logic signed [31:0] x, logic signed [31:0] y,
                                               logic signed [31:0] z);
      pixel_type p;
      longint xn, yn, xd, yd, xx, yy, xy, r2, r4, r6, a1, a2, a3, num, den, ratio;
      p.u = '0; p.v = '0; p.ok = 1'b0;
      if (z <= 0) return p;
      xn = div_round(longint'(x), longint'(z));
      yn = div_round(longint'(y), longint'(z));
      if (shadow[REG_BYPASS][0]) begin
         xd = xn; yd = yn;
      end else begin
         xx = mul_round(xn, xn); yy = mul_round(yn, yn); xy = mul_round(xn, yn);
         r2 = clamp_inner(xx + yy);
         r4 = mul_round(r2, r2);
         r6 = mul_round(r4, r2);
         a1 = clamp_inner(xy + xy);
         a2 = clamp_inner(r2 + clamp_inner(xx + xx));
         a3 = clamp_inner(r2 + clamp_inner(yy + yy));
         num = clamp_inner(ONE + mul_round(half(shadow[REG_K1K2], 1), r2));
         num = clamp_inner(num + mul_round(half(shadow[REG_K1K2], 0), r4));
         num = clamp_inner(num + mul_round(half(shadow[REG_K3K4], 1), r6));
         den = clamp_inner(ONE + mul_round(half(shadow[REG_K3K4], 0), r2));
         den = clamp_inner(den + mul_round(half(shadow[REG_K5K6], 1), r4));
         den = clamp_inner(den + mul_round(half(shadow[REG_K5K6], 0), r6));
         if (den == 0) return p;
         ratio = div_round(num, den);
         xd = clamp_inner(mul_round(xn, ratio) + mul_round(half(shadow[REG_P1P2], 1), a1));
         xd = clamp_inner(xd + mul_round(half(shadow[REG_P1P2], 0), a2));
         yd = clamp_inner(mul_round(yn, ratio) + mul_round(half(shadow[REG_P1P2], 1), a3));
         yd = clamp_inner(yd + mul_round(half(shadow[REG_P1P2], 0), a1));
      end
      p.u = 32'(clamp_out(mul_round(half(shadow[REG_FXY], 1), xd) + half(shadow[REG_CXY], 1)));
      p.v = 32'(clamp_out(mul_round(half(shadow[REG_FXY], 0), yd) + half(shadow[REG_CXY], 0)));
      p.ok = 1'b1;
      return p;
   endfunction

   function automatic int gap_len();
      if (no_gaps) return 0;
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response back-pressure
   initial begin
      int n;
      forever begin
         @(negedge clock);
         rsp_ready <= 1'b1;
         n = no_gaps ? 20 : $urandom_range(1, 12);
         repeat (n) @(negedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      pixel_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result u=%0d v=%0d", rsp_pixel_u, rsp_pixel_v);
            errors++;
         end else begin
            e = pending_pixels.pop_front();
            if (!rsp_valid_res) invalid_seen++;
            if (rsp_pixel_u !== e.u) begin
               $error("pixel_u expected %0d actual %0d", e.u, rsp_pixel_u); errors++;
            end
            if (rsp_pixel_v !== e.v) begin
               $error("pixel_v expected %0d actual %0d", e.v, rsp_pixel_v); errors++;
            end
            if (rsp_valid_res !== e.ok) begin
               $error("valid_res expected %0d actual %0d", e.ok, rsp_valid_res); errors++;
            end
         end
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      do @(posedge clock); while (!req_ready);
      pending_pixels.push_back(project_point(x, y, z));
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [63:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx < 3'd7) shadow[idx] = (idx == REG_BYPASS) ? {63'd0, data[0]} : data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic rand_point(output logic signed [31:0] x, output logic signed [31:0] y,
                             output logic signed [31:0] z);
      int sel;
      sel = $urandom_range(0, 19);
      x = $signed($urandom) >>> $urandom_range(6, 18);
      y = $signed($urandom) >>> $urandom_range(6, 18);
      z = $urandom_range(32'h0000_1000, 32'h0040_0000);
      if (sel == 0) begin
         x = $urandom; y = $urandom; z = $urandom;
      end else if (sel == 1) begin
         z = -$signed($urandom_range(0, 32'h7fff_ffff));
      end else if (sel == 2) begin
         z = $urandom_range(1, 32'h7fff_ffff);
      end
   endtask

   function automatic logic [63:0] rand_pair(int lo_sh, int hi_sh);
      logic signed [31:0] a, b;
      a = $signed($urandom) >>> $urandom_range(lo_sh, hi_sh);
      b = $signed($urandom) >>> $urandom_range(lo_sh, hi_sh);
      return {a, b};
   endfunction

   task automatic load_lens(logic [63:0] k12, logic [63:0] k34, logic [63:0] k56,
                            logic [63:0] p12, logic [63:0] fxy, logic [63:0] cxy,
                            logic bypass);
      csr_write(REG_K1K2, k12);
      csr_write(REG_K3K4, k34);
      csr_write(REG_K5K6, k56);
      csr_write(REG_P1P2, p12);
      csr_write(REG_FXY, fxy);
      csr_write(REG_CXY, cxy);
      csr_write(REG_BYPASS, {63'd0, bypass});
   endtask

   // bypass path with reset registers and extreme coordinates
   task automatic test_bypass_extremes();
      send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
      drain();
      load_lens('0, '0, '0, '0, {32'sd500 << 16, 32'sd500 << 16},
                {32'sd320 << 16, 32'sd240 << 16}, 1'b1);
      send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001);
      send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
      send_point(32'sh0000_1234, 32'shffff_0000, 32'sh8000_0000);
      send_point(32'sh0000_8000, 32'shffff_8000, 32'sh0001_0000);
      send_point(32'sh0000_0001, 32'shffff_ffff, 32'sh0000_0002);
      drain();
      // full-scale focal and center: saturation at the output
      load_lens({32'sh1234_5678, 32'sh0}, '1, '1, '1, {32'sh7fff_ffff, 32'sh8000_0000},
                {32'sh7fff_ffff, 32'sh8000_0000}, 1'b1);
      send_point(32'sh0100_0000, 32'sh0100_0000, 32'sh0001_0000);
      send_point(32'shff00_0000, 32'shff00_0000, 32'sh0001_0000);
      drain();
   endtask

   // distortion path: ratio, tangential terms, zero denominator
   task automatic test_distortion_directed();
      load_lens({32'shff80_0000, 32'sh0040_0000}, {32'sh0010_0000, 32'shff00_0000},
                '0, {32'sh0001_0000, 32'shffff_0000},
                {32'sd600 << 16, 32'sd600 << 16}, {32'sd320 << 16, 32'sd240 << 16}, 1'b0);
      // x/z = 1, y = 0 makes the denominator exactly zero
      send_point(32'sh0002_0000, 32'sh0000_0000, 32'sh0002_0000);
      send_point(32'sh0000_8000, 32'sh0000_4000, 32'sh0001_0000);
      send_point(32'shffff_8000, 32'sh0000_c000, 32'sh0001_0000);
      send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000);
      send_point(32'sh0001_0000, 32'sh0001_0000, 32'shffff_0000);
      drain();
      // extreme coefficients drive the distortion pipeline into saturation
      load_lens({32'sh7fff_ffff, 32'sh8000_0000}, {32'sh7fff_ffff, 32'sh8000_0000},
                {32'sh7fff_ffff, 32'sh8000_0000}, {32'sh7fff_ffff, 32'sh8000_0000},
                {32'sd1000 << 16, 32'sd1000 << 16}, '0, 1'b0);
      send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh0000_0001);
      send_point(32'sh0003_0000, 32'shfffd_0000, 32'sh0001_0000);
      send_point(32'sh0000_1000, 32'sh0000_1000, 32'sh0001_0000);
      drain();
      // an index past the register list is ignored
      csr_write(IDX_UNUSED, '1);
      send_point(32'sh0000_4000, 32'sh0000_2000, 32'sh0001_0000);
      drain();
   endtask

   // random points over several lens settings
   task automatic test_random_phases();
      logic signed [31:0] x, y, z;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 5)
            load_lens($urandom, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
         else
            load_lens(rand_pair(7, 12), rand_pair(7, 12), rand_pair(9, 14), rand_pair(12, 16),
                      {32'($urandom_range(100, 2000)) << 16, 32'($urandom_range(100, 2000)) << 16},
                      {32'($urandom_range(0, 1000)) << 16, 32'($urandom_range(0, 1000)) << 16},
                      ph == 1);
         no_gaps = (ph == 2);
         repeat (200) begin
            rand_point(x, y, z);
            send_point(x, y, z);
         end
         drain();
      end
      no_gaps = 0;
   endtask

   initial begin
      shadow[REG_K1K2] = '0; shadow[REG_K3K4] = '0; shadow[REG_K5K6] = '0;
      shadow[REG_P1P2] = '0; shadow[REG_FXY] = '0; shadow[REG_CXY] = '0;
      shadow[REG_BYPASS] = 64'd1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_bypass_extremes();
      test_distortion_directed();
      test_random_phases();
      drain();
      repeat (TOTAL_LAT + 20) @(negedge clock);
      $display("covered %0d requests (%0d flagged invalid) over bypass, distortion and",
               requests_sent, invalid_seen);
      $display("saturating lens settings with random stalls on both channels");
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/rld_pkg.sv
sv/rld_mul.sv
sv/rld_div.sv
sv/rld_norm.sv
sv/rld_distort.sv
sv/rld_pixel.sv
sv/rational_lens_distort_project.sv
sim/rational_lens_distort_project_test.sv
